[rtl/core/port_bitmap_find_next_set_macros.svh]
// Assertion macros used by the port bitmap engine.
`ifndef PORT_BITMAP_FIND_NEXT_SET_MACROS_SVH
`define PORT_BITMAP_FIND_NEXT_SET_MACROS_SVH
`ifndef SYNTHESIS
// The condition must never hold while out of reset.
`define PBFNS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define PBFNS_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define PBFNS_NEVER(label, clk, rst_n, expr)
`define PBFNS_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/pbfns_pkg.sv]
// Shared types and constants for the port bitmap block.
package pbfns_pkg;

    // Default geometry of the bitmap.
    localparam int PORT_COUNT_DEF = 65536;
    localparam int WORD_BITS_DEF  = 64;

    // Field widths.
    localparam int OP_W   = 3;
    localparam int PORT_W = 16;
    localparam int RANK_W = 17;
    localparam int CNT_W  = 17;

    // Depth of the queues on either side of the engine.
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes.
    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd4;
    localparam logic [OP_W-1:0] OP_TAKE  = 3'd5;

    // Work classes handed from the front end to the engine.
    typedef enum logic [2:0] {
        K_SET,
        K_CLR,
        K_TEST,
        K_FIND,
        K_TAKE,
        K_REPORT
    } t_kind;

    // A classified command. For find, port holds the first port to examine.
    typedef struct packed {
        t_kind             kind;
        logic [PORT_W-1:0] port;
        logic [RANK_W-1:0] rank;
    } t_cmd;

    // One result transaction.
    typedef struct packed {
        logic [PORT_W-1:0] result_port;
        logic              found;
        logic              bit_value;
        logic [CNT_W-1:0]  marked_count;
    } t_res;

endpackage

[rtl/core/pbfns_fifo.sv]
// Small first-in first-out queue built from registers.
module pbfns_fifo import pbfns_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_Q-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_Q'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill-level updates, wrapping at the depth.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/pbfns_front.sv]
// Front end: accepts input transactions, classifies them and queues commands.
module pbfns_front import pbfns_pkg::*; #(
    parameter int PORT_COUNT = PORT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [PORT_W-1:0] i_port,
    input  logic [RANK_W-1:0] i_rank,
    input  logic              i_hold,
    input  logic              i_cmd_pop,
    output logic              o_cmd_empty,
    output t_cmd              o_cmd
);
    t_cmd            cmd;
    logic            q_full;
    logic            in_map;
    logic [PORT_W:0] next_port;
    logic [$bits(t_cmd)-1:0] q_out;

    assign in_map    = (32'(i_port) < PORT_COUNT);
    assign next_port = {1'b0, i_port} + 1'b1;

    // Operations that can have no effect are reduced to a plain report.
    always_comb begin
        cmd.port = i_port;
        cmd.rank = i_rank;
        unique case (i_opcode)
            OP_SET:   cmd.kind = in_map ? K_SET : K_REPORT;
            OP_CLEAR: cmd.kind = in_map ? K_CLR : K_REPORT;
            OP_TEST:  cmd.kind = in_map ? K_TEST : K_REPORT;
            OP_FIND: begin
                cmd.port = next_port[PORT_W-1:0];
                cmd.kind = (32'(next_port) < PORT_COUNT) ? K_FIND : K_REPORT;
            end
            OP_COUNT: cmd.kind = K_REPORT;
            OP_TAKE:  cmd.kind = (i_rank != '0) ? K_TAKE : K_REPORT;
            default:  cmd.kind = K_REPORT;
        endcase
    end

    // Nothing is taken in while the engine clears the bitmap.
    assign o_full = q_full || i_hold;
    assign o_cmd  = t_cmd'(q_out);

    pbfns_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !i_hold),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_out),
        .o_empty (o_cmd_empty)
    );

endmodule

[rtl/core/pbfns_back.sv]
// Engine: holds the bitmap memory and carries out one command at a time.
`include "port_bitmap_find_next_set_macros.svh"
module pbfns_back import pbfns_pkg::*; #(
    parameter int PORT_COUNT = PORT_COUNT_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_empty,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res,
    output logic o_busy
);
    localparam int WORD_TOTAL = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT,
        ST_CHECK,
        ST_SELECT
    } t_state;

    typedef logic [WORD_BITS-1:0] t_word;

    // Number of ones in a word, summed pairwise as a balanced tree.
    function automatic logic [BIT_W:0] ones_in(input t_word w);
        logic [BIT_W:0] s [WORD_BITS];
        for (int i = 0; i < WORD_BITS; i++) begin
            s[i] = (BIT_W + 1)'(w[i]);
        end
        for (int step = 1; step < WORD_BITS; step = step * 2) begin
            for (int i = 0; i + step < WORD_BITS; i = i + 2 * step) begin
                s[i] = s[i] + s[i + step];
            end
        end
        return s[0];
    endfunction

    // Index of the lowest set bit; zero for an empty word.
    function automatic logic [BIT_W-1:0] lowest_set(input t_word w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    t_word             r_mem [WORD_TOTAL];
    t_word             r_rdata;
    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [RANK_W-1:0] r_rank, n_rank;
    t_word             r_mask, n_mask;
    t_word             r_sel, n_sel;
    t_word             r_word, n_word;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              mem_we;
    t_word             mem_wd;
    logic              last_word;
    logic              cur_bit;
    t_word             bit_mask;
    t_word             hits;
    t_word             cand;
    logic [BIT_W:0]    cand_ones;
    logic [BIT_W-1:0]  sel_idx;
    logic [PORT_W-1:0] word_base;

    assign last_word = (r_addr == ADDR_W'(WORD_TOTAL - 1));
    assign cur_bit   = r_rdata[r_bit];
    assign bit_mask  = t_word'(1) << r_bit;
    assign hits      = r_rdata & r_mask;
    // Port 0 never takes part in ranking.
    assign cand      = (r_addr == '0) ? (r_rdata & ~t_word'(1)) : r_rdata;
    assign cand_ones = ones_in(cand);
    assign sel_idx   = lowest_set(r_sel);
    assign word_base = PORT_W'(r_addr) << BIT_W;
    assign o_busy    = (r_state == ST_CLEAR);

    // Sequencer: next state, memory write and result transaction.
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_bit      = r_bit;
        n_rank     = r_rank;
        n_mask     = r_mask;
        n_sel      = r_sel;
        n_word     = r_word;
        n_count    = r_count;
        mem_we     = 1'b0;
        mem_wd     = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (last_word) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = i_cmd.kind;
                    n_bit     = i_cmd.port[BIT_W-1:0];
                    n_addr    = ADDR_W'(i_cmd.port >> BIT_W);
                    n_rank    = i_cmd.rank;
                    n_mask    = '1 << i_cmd.port[BIT_W-1:0];
                    unique case (i_cmd.kind)
                        K_REPORT: begin
                            o_res_push         = 1'b1;
                            o_res.marked_count = r_count;
                        end
                        K_TAKE: begin
                            n_addr  = '0;
                            n_state = ST_WAIT;
                        end
                        default: n_state = ST_WAIT;
                    endcase
                end
            end
            ST_WAIT: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                unique case (r_kind)
                    K_SET: begin
                        if (!cur_bit) begin
                            mem_we  = 1'b1;
                            mem_wd  = r_rdata | bit_mask;
                            n_count = r_count + 1'b1;
                        end
                        o_res_push         = 1'b1;
                        o_res.marked_count = n_count;
                        n_state            = ST_IDLE;
                    end
                    K_CLR: begin
                        if (cur_bit) begin
                            mem_we  = 1'b1;
                            mem_wd  = r_rdata & ~bit_mask;
                            n_count = r_count - 1'b1;
                        end
                        o_res_push         = 1'b1;
                        o_res.marked_count = n_count;
                        n_state            = ST_IDLE;
                    end
                    K_TEST: begin
                        o_res_push         = 1'b1;
                        o_res.bit_value    = cur_bit;
                        o_res.marked_count = r_count;
                        n_state            = ST_IDLE;
                    end
                    K_FIND: begin
                        if (hits != '0) begin
                            o_res_push        = 1'b1;
                            o_res.found       = 1'b1;
                            o_res.result_port = word_base | PORT_W'(lowest_set(hits));
                            o_res.marked_count = r_count;
                            n_state           = ST_IDLE;
                        end else if (last_word) begin
                            o_res_push         = 1'b1;
                            o_res.marked_count = r_count;
                            n_state            = ST_IDLE;
                        end else begin
                            n_addr  = r_addr + 1'b1;
                            n_mask  = '1;
                            n_state = ST_WAIT;
                        end
                    end
                    K_TAKE: begin
                        if (r_rank > RANK_W'(cand_ones)) begin
                            n_rank = r_rank - RANK_W'(cand_ones);
                            if (last_word) begin
                                o_res_push         = 1'b1;
                                o_res.marked_count = r_count;
                                n_state            = ST_IDLE;
                            end else begin
                                n_addr  = r_addr + 1'b1;
                                n_state = ST_WAIT;
                            end
                        end else begin
                            n_sel   = cand;
                            n_word  = r_rdata;
                            n_state = ST_SELECT;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_SELECT: begin
                // Drop one candidate per cycle until the ranked one is lowest.
                if (r_rank == RANK_W'(1)) begin
                    mem_we             = 1'b1;
                    mem_wd             = r_word & ~(t_word'(1) << sel_idx);
                    n_count            = r_count - 1'b1;
                    o_res_push         = 1'b1;
                    o_res.found        = 1'b1;
                    o_res.result_port  = word_base | PORT_W'(sel_idx);
                    o_res.marked_count = n_count;
                    n_state            = ST_IDLE;
                end else begin
                    n_sel  = r_sel & (r_sel - 1'b1);
                    n_rank = r_rank - 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_count <= '0;
            r_kind  <= K_REPORT;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_kind  <= n_kind;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_bit  <= n_bit;
        r_rank <= n_rank;
        r_mask <= n_mask;
        r_sel  <= n_sel;
        r_word <= n_word;
    end

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wd;
        end
        r_rdata <= r_mem[r_addr];
    end

    `PBFNS_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(PORT_COUNT))
    `PBFNS_NEVER(a_push_full, i_clk, i_rst_n, o_res_push && i_res_full)
    `PBFNS_NEVER(a_pop_in_clear, i_clk, i_rst_n, o_cmd_pop && (r_state == ST_CLEAR))
    `PBFNS_IMPLIES(a_found_port, i_clk, i_rst_n, o_res_push && o_res.found, o_res.result_port != '0)

endmodule

[rtl/core/port_bitmap_find_next_set.sv]
// Top level of the port bitmap with find-next, count and ranked take.
//
//  Channel   | Handshake         | Payload
//  ----------+-------------------+-------------------------------------------------
//  command   | push / full       | i_opcode, i_port, i_rank
//  result    | empty / pop       | o_result_port, o_found, o_bit_value, o_marked_count
//
// Count and no-op commands are answered from the idle state; set, clear and test
// pass through a wait and a check state. Find-next scans bitmap words from the
// start port, one memory read each; take-ranked scans from word 0 and then also
// picks the bit within its word. After reset the memory is swept clear, one word per cycle,
// with full held high. Two-entry queues on each side decouple the stalls.
module port_bitmap_find_next_set import pbfns_pkg::*; #(
    parameter int PORT_COUNT = PORT_COUNT_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [PORT_W-1:0] i_port,
    input  logic [RANK_W-1:0] i_rank,
    output logic              empty,
    input  logic              pop,
    output logic [PORT_W-1:0] o_result_port,
    output logic              o_found,
    output logic              o_bit_value,
    output logic [CNT_W-1:0]  o_marked_count
);
    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;
    logic busy;
    logic res_push;
    logic res_full;
    t_res res_in;
    t_res res_out;
    logic [$bits(t_res)-1:0] res_q;

    pbfns_front #(
        .PORT_COUNT (PORT_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_port      (i_port),
        .i_rank      (i_rank),
        .i_hold      (busy),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_empty (cmd_empty),
        .o_cmd       (cmd)
    );

    pbfns_back #(
        .PORT_COUNT (PORT_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_busy      (busy)
    );

    // Result queue towards the consumer.
    pbfns_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out        = t_res'(res_q);
    assign o_result_port  = res_out.result_port;
    assign o_found        = res_out.found;
    assign o_bit_value    = res_out.bit_value;
    assign o_marked_count = res_out.marked_count;

endmodule
